/* hdl/dpba_pkg.sv */
// Shared types and constants for the dictionary packed bit array core.
// No dependencies.
package dpba_pkg;
	localparam int MAX_ENTRIES   = 4096;
	localparam int MAX_CODE_BITS = 8;
	localparam int IDX_W  = $clog2(MAX_ENTRIES);
	localparam int CFG_W  = 13;
	localparam int VAL_W  = 31;
	localparam int CODE_W = MAX_CODE_BITS;
	localparam int CNT_W  = MAX_CODE_BITS + 1;
	localparam int WID_W  = 4;
	localparam int DICT_DEPTH = 1 << MAX_CODE_BITS;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_OVF = 2'd1;
	localparam logic [1:0] ST_OOB = 2'd2;

	localparam logic [WID_W-1:0] WID_MAX = WID_W'(MAX_CODE_BITS);

	typedef struct packed {
		logic clr_step;
		logic capture;
		logic store_rd;
		logic dict_rd;
		logic dict_sel_code;
		logic k_inc;
		logic commit;
		logic commit_found;
		logic resp_oob;
		logic resp_read;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic oob;
		logic is_wr;
		logic match;
		logic k_last;
	} dp_stat_t;
endpackage

/* hdl/dpba_datapath.sv */
// Datapath: code store, dictionary memory, width/count registers, result registers.
// Depends on dpba_pkg.
module dpba_datapath
	import dpba_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             cmd,
	input  logic [IDX_W-1:0] index,
	input  logic [VAL_W-1:0] value,
	input  dp_cmd_t          dc,
	output dp_stat_t         ds,
	output logic             done,
	output logic [VAL_W-1:0] read_value,
	output logic [1:0]       status,
	output logic [WID_W-1:0] code_width,
	output logic [CNT_W-1:0] unique_count
);
	logic [CODE_W-1:0] store_mem [MAX_ENTRIES];
	logic [VAL_W-1:0]  dict_mem [DICT_DEPTH];

	logic [CFG_W-1:0]  n_q;
	logic [IDX_W-1:0]  clr_cnt_q;
	logic [WID_W-1:0]  wid_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              cmd_q;
	logic [IDX_W-1:0]  idx_q;
	logic [VAL_W-1:0]  val_q;
	logic [CODE_W-1:0] k_q;
	logic [CODE_W-1:0] store_rdata_q;
	logic [VAL_W-1:0]  dict_rdata_q;
	logic              done_q;
	logic [VAL_W-1:0]  rv_q;
	logic [1:0]        st_q;

	logic [CNT_W-1:0]  code9;
	logic              need_widen;
	logic              ovf;
	logic              dict_we;
	logic [CODE_W-1:0] dict_waddr;
	logic [VAL_W-1:0]  dict_wdata;
	logic              store_we;
	logic [IDX_W-1:0]  store_waddr;
	logic [CODE_W-1:0] store_wdata;
	logic [CODE_W-1:0] dict_raddr;
	logic [CFG_W-1:0]  cfg_sat;

	assign code9      = dc.commit_found ? {1'b0, k_q} : cnt_q;
	assign need_widen = (code9 >> wid_q) != '0;
	assign ovf        = need_widen && (wid_q == WID_MAX);
	assign cfg_sat    = (cfg_wdata > CFG_W'(MAX_ENTRIES)) ? CFG_W'(MAX_ENTRIES) : cfg_wdata;

	always_comb begin
		dict_we     = 1'b0;
		dict_waddr  = cnt_q[CODE_W-1:0];
		dict_wdata  = val_q;
		store_we    = 1'b0;
		store_waddr = idx_q;
		store_wdata = code9[CODE_W-1:0];
		if (dc.clr_step) begin
			store_we    = 1'b1;
			store_waddr = clr_cnt_q;
			store_wdata = '0;
			// entry zero of the dictionary always decodes to zero
			dict_we     = (clr_cnt_q == '0);
			dict_waddr  = '0;
			dict_wdata  = '0;
		end else if (dc.commit && !ovf) begin
			store_we = 1'b1;
			dict_we  = !dc.commit_found;
		end
	end

	assign dict_raddr = dc.dict_sel_code ? store_rdata_q : k_q;

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[store_waddr] <= store_wdata;
		end
		if (dc.store_rd) begin
			store_rdata_q <= store_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (dict_we) begin
			dict_mem[dict_waddr] <= dict_wdata;
		end
		if (dc.dict_rd) begin
			dict_rdata_q <= dict_mem[dict_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (dc.capture) begin
			cmd_q <= cmd;
			idx_q <= index;
			val_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= CFG_W'(MAX_ENTRIES);
			clr_cnt_q <= '0;
			wid_q     <= WID_W'(1);
			cnt_q     <= CNT_W'(1);
			k_q       <= '0;
			done_q    <= 1'b0;
			rv_q      <= '0;
			st_q      <= ST_OK;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				n_q       <= cfg_sat;
				clr_cnt_q <= '0;
				wid_q     <= WID_W'(1);
				cnt_q     <= CNT_W'(1);
			end else begin
				if (dc.clr_step) begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
				end
				if (dc.capture) begin
					k_q <= '0;
				end else if (dc.k_inc) begin
					k_q <= k_q + 1'b1;
				end
				if (dc.resp_oob) begin
					done_q <= 1'b1;
					rv_q   <= '0;
					st_q   <= ST_OOB;
				end
				if (dc.resp_read) begin
					done_q <= 1'b1;
					rv_q   <= dict_rdata_q;
					st_q   <= ST_OK;
				end
				if (dc.commit) begin
					done_q <= 1'b1;
					rv_q   <= '0;
					st_q   <= ovf ? ST_OVF : ST_OK;
					if (!ovf) begin
						if (need_widen) begin
							wid_q <= wid_q + 1'b1;
						end
						if (!dc.commit_found) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
			end
		end
	end

	assign ds.clr_last = (clr_cnt_q == '1);
	assign ds.oob      = {1'b0, idx_q} >= n_q;
	assign ds.is_wr    = cmd_q;
	assign ds.match    = (dict_rdata_q == val_q);
	assign ds.k_last   = ({1'b0, k_q} + CNT_W'(1)) == cnt_q;

	assign done         = done_q;
	assign read_value   = rv_q;
	assign status       = st_q;
	assign code_width   = wid_q;
	assign unique_count = cnt_q;

`ifndef SYNTHESIS
	a_width_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wid_q >= WID_W'(1)) && (wid_q <= WID_MAX))
		else $error("code width out of range");
	a_count_fits: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (CNT_W'(1) << wid_q))
		else $error("dictionary count exceeds code space");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("back to back result strobes");
`endif
endmodule

/* hdl/dpba_ctrl.sv */
// Controller FSM: clearing pass, request sequencing, dictionary search.
// Depends on dpba_pkg.
module dpba_ctrl
	import dpba_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic     start,
	input  dp_stat_t ds,
	output dp_cmd_t  dc,
	output logic     busy
);
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_RCODE = 3'd3;
	localparam logic [2:0] S_RVAL  = 3'd4;
	localparam logic [2:0] S_SCMP  = 3'd5;
	localparam logic [2:0] S_SRD   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		dc      = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				dc.clr_step = 1'b1;
				if (ds.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					dc.capture = 1'b1;
					state_d    = S_CHECK;
				end
			end
			S_CHECK: begin
				if (ds.oob) begin
					dc.resp_oob = 1'b1;
					state_d     = S_IDLE;
				end else if (!ds.is_wr) begin
					dc.store_rd = 1'b1;
					state_d     = S_RCODE;
				end else begin
					dc.dict_rd = 1'b1;
					state_d    = S_SCMP;
				end
			end
			S_RCODE: begin
				dc.dict_rd       = 1'b1;
				dc.dict_sel_code = 1'b1;
				state_d          = S_RVAL;
			end
			S_RVAL: begin
				dc.resp_read = 1'b1;
				state_d      = S_IDLE;
			end
			S_SCMP: begin
				// linear search over codes in use
				if (ds.match) begin
					dc.commit       = 1'b1;
					dc.commit_found = 1'b1;
					state_d         = S_IDLE;
				end else if (ds.k_last) begin
					dc.commit = 1'b1;
					state_d   = S_IDLE;
				end else begin
					dc.k_inc = 1'b1;
					state_d  = S_SRD;
				end
			end
			S_SRD: begin
				dc.dict_rd = 1'b1;
				state_d    = S_SCMP;
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else if (cfg_we) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
endmodule

/* hdl/dictionary_packed_bit_array_core.sv */
// Read: code store, then dictionary, then result. Write: linear dictionary search
// over the codes in use. Index out of range: answered without a memory access.
// One request at a time; done pulses one cycle and cannot be stalled.
// After reset and after every cfg_we write, busy stays high during a
// clearing pass over the whole code store.
// Depends on dpba_pkg, dpba_ctrl, dpba_datapath.
module dictionary_packed_bit_array_core
	import dpba_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             start,
	output logic             busy,
	input  logic             cmd,
	input  logic [IDX_W-1:0] index,
	input  logic [VAL_W-1:0] value,
	output logic             done,
	output logic [VAL_W-1:0] read_value,
	output logic [1:0]       status,
	output logic [WID_W-1:0] code_width,
	output logic [CNT_W-1:0] unique_count
);
	dp_cmd_t  dc;
	dp_stat_t ds;

	dpba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_we (cfg_we),
		.start  (start),
		.ds     (ds),
		.dc     (dc),
		.busy   (busy)
	);

	dpba_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.index        (index),
		.value        (value),
		.dc           (dc),
		.ds           (ds),
		.done         (done),
		.read_value   (read_value),
		.status       (status),
		.code_width   (code_width),
		.unique_count (unique_count)
	);

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !cfg_we) |=> busy)
		else $error("request accepted without going busy");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a request in flight");
	a_ovf_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (read_value == '0))
		else $error("nonzero value on failed request");
`endif
endmodule
